// ----- design/qke_pkg.sv -----
// ----------------------------------------------------------------------------
// qke_pkg
// Shared types, widths and helpers for the point to quad key encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qke_pkg;

	localparam int COORD_W     = 32;
	localparam int CELL_W      = 32;
	localparam int DEPTH_W     = 5;
	localparam int KEY_W       = 59;
	localparam int CODE_W      = 2 * CELL_W;
	localparam int DEPTH_LIMIT = 29;
	localparam int DIV_STEPS   = CELL_W;
	// offset stage + prep stage + one stage per quotient bit
	localparam int CELL_LAT    = DIV_STEPS + 2;
	// cell pipeline plus the key output register
	localparam int RESULT_LAT  = CELL_LAT + 1;

	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [1:0] {
		CFG_LOW_X,
		CFG_LOW_Y,
		CFG_SPAN_X,
		CFG_SPAN_Y
	} cfg_idx_t;

	typedef struct packed {
		logic               vld;
		logic               err;
		logic [DEPTH_W-1:0] depth;
	} key_ctl_t;

	// x into even bits, y into odd bits
	function automatic logic [CODE_W-1:0] interleave(cell_t x, cell_t y);
		logic [CODE_W-1:0] code;
		for (int i = 0; i < CELL_W; i++) begin
			code[2*i]   = x[i];
			code[2*i+1] = y[i];
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- design/qke_cell.sv -----
// ----------------------------------------------------------------------------
// qke_cell
// Offsets one coordinate by the low bound and scales it to a 32-bit cell
// number, floor(off * (2^32-1) / span) with clamping, through a pipelined
// restoring divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qke_cell import qke_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [COORD_W-1:0] coord,
	input  wire logic signed [COORD_W-1:0] low,
	input  wire logic        [CELL_W-1:0]  span,
	output cell_t                          cell_num
);

	// off - 1, so that off > 0 is just a clear sign bit
	logic signed [COORD_W:0] offm1;
	assign offm1 = {coord[COORD_W-1], coord} - {low[COORD_W-1], low} - (COORD_W+1)'(1);

	logic [CELL_W-1:0] offm1_s1;
	logic              pos_s1;

	always_ff @(posedge clk) begin
		offm1_s1 <= offm1[CELL_W-1:0];
		pos_s1   <= ~offm1[COORD_W];
	end

	// off * (2^32-1) = {off-1, -off}; quotient overflows when the high half >= span
	logic [CELL_W-1:0] rem_sn  [DIV_STEPS+1];
	logic [CELL_W-1:0] dq_sn   [DIV_STEPS+1];
	logic              sat_sn  [DIV_STEPS+1];
	logic              zero_sn [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		rem_sn[0]  <= offm1_s1;
		dq_sn[0]   <= ~offm1_s1;
		sat_sn[0]  <= pos_s1 && (offm1_s1 >= span);
		zero_sn[0] <= ~pos_s1;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [CELL_W:0]   trial;
		logic [CELL_W-1:0] diff;
		logic              ge;

		assign trial = {rem_sn[k], dq_sn[k][CELL_W-1]};
		// remainder stays below span, so the low bits of the difference suffice
		assign diff  = trial[CELL_W-1:0] - span;
		assign ge    = trial >= {1'b0, span};

		// dividend bits shift out the top, quotient bits shift in the bottom
		always_ff @(posedge clk) begin
			rem_sn[k+1]  <= ge ? diff : trial[CELL_W-1:0];
			dq_sn[k+1]   <= {dq_sn[k][CELL_W-2:0], ge};
			sat_sn[k+1]  <= sat_sn[k];
			zero_sn[k+1] <= zero_sn[k];
		end
	end

	always_comb begin
		if (sat_sn[DIV_STEPS]) begin
			cell_num = '1;
		end else if (zero_sn[DIV_STEPS]) begin
			cell_num = '0;
		end else begin
			cell_num = dq_sn[DIV_STEPS];
		end
	end

endmodule

`default_nettype wire

// ----- design/qke_key.sv -----
// ----------------------------------------------------------------------------
// qke_key
// Interleaves the two cell numbers, keeps the top 2*depth bits under a
// marker bit, zeroes the key on a depth error and registers the result with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module qke_key import qke_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire key_ctl_t         ctl,
	input  wire cell_t            cell_x,
	input  wire cell_t            cell_y,
	output logic                  done,
	output logic [KEY_W-1:0]      tile_key,
	output logic                  depth_error
);

	localparam int SHAMT_W = $clog2(CODE_W + 1);

	logic [CODE_W-1:0]  code;
	logic [SHAMT_W-1:0] shamt;
	logic [CODE_W:0]    marked;
	logic [KEY_W-1:0]   key;

	assign code  = interleave(cell_x, cell_y);
	// marker sits just above the code, so depth zero leaves the marker alone
	assign shamt  = SHAMT_W'(CODE_W) - SHAMT_W'({ctl.depth, 1'b0});
	assign marked = {1'b1, code} >> shamt;
	assign key    = ctl.err ? '0 : marked[KEY_W-1:0];

	logic             done_q;
	logic [KEY_W-1:0] key_q;
	logic             err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key;
		err_q <= ctl.err;
	end

	assign done        = done_q;
	assign tile_key    = key_q;
	assign depth_error = err_q;

endmodule

`default_nettype wire

// ----- design/point_to_quad_key_encoder.sv -----
// ----------------------------------------------------------------------------
// point_to_quad_key_encoder
// Maps a fixed-point point and a tree depth to its quad-tree cell key.
// The start transfer passes two offset/prep stages, 32 divider stages and one key
// stage before done pulses. Throughput: one point per cycle.
// busy stays low; each coordinate has its own 32-stage divider pipeline.
// Reset clears the valid line and sets low = 0, span = 1 on both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module point_to_quad_key_encoder import qke_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [COORD_W-1:0] point_x,
	input  wire logic signed [COORD_W-1:0] point_y,
	input  wire logic        [DEPTH_W-1:0] tree_depth,
	output logic                           done,
	output logic             [KEY_W-1:0]   tile_key,
	output logic                           depth_error,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic        [1:0]         cfg_index,
	input  wire logic        [31:0]        cfg_data
);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic signed [COORD_W-1:0] low_x_q;
	logic signed [COORD_W-1:0] low_y_q;
	logic        [CELL_W-1:0]  span_x_q;
	logic        [CELL_W-1:0]  span_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q  <= '0;
			low_y_q  <= '0;
			span_x_q <= CELL_W'(1);
			span_y_q <= CELL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOW_X:  low_x_q  <= cfg_data;
				CFG_LOW_Y:  low_y_q  <= cfg_data;
				CFG_SPAN_X: span_x_q <= cfg_data;
				CFG_SPAN_Y: span_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control line running alongside the cell pipelines
	key_ctl_t ctl_sn [CELL_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_LAT; i++) begin
				ctl_sn[i] <= '0;
			end
		end else begin
			ctl_sn[0].vld   <= start && !busy;
			ctl_sn[0].err   <= tree_depth > DEPTH_W'(DEPTH_LIMIT);
			ctl_sn[0].depth <= tree_depth;
			for (int i = 1; i < CELL_LAT; i++) begin
				ctl_sn[i] <= ctl_sn[i-1];
			end
		end
	end

	cell_t cell_x;
	cell_t cell_y;

	qke_cell u_cell_x (
		.clk      (clk),
		.coord    (point_x),
		.low      (low_x_q),
		.span     (span_x_q),
		.cell_num (cell_x)
	);

	qke_cell u_cell_y (
		.clk      (clk),
		.coord    (point_y),
		.low      (low_y_q),
		.span     (span_y_q),
		.cell_num (cell_y)
	);

	qke_key u_key (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl_sn[CELL_LAT-1]),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.done        (done),
		.tile_key    (tile_key),
		.depth_error (depth_error)
	);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##RESULT_LAT done)
		else $error("result strobe missing at fixed latency");

	a_err_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && depth_error |-> tile_key == '0)
		else $error("depth error with nonzero key");

	a_marker_present: assert property (@(posedge clk) disable iff (!arst_n)
		done && !depth_error |-> tile_key != '0)
		else $error("valid key lost its marker bit");

endmodule

`default_nettype wire

// ----- tb/point_to_quad_key_encoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_to_quad_key_encoder_tb
// Drives points and depths through the quad key encoder under several bound
// settings. An in-bench predictor computes each key, and a checker compares
// every done pulse, field by field, against the oldest pending key.
// ----------------------------------------------------------------------------

module point_to_quad_key_encoder_tb;
	import qke_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_POINTS   = 240;

	localparam logic [DEPTH_W-1:0] TOP_DEPTH  = DEPTH_W'(DEPTH_LIMIT);
	localparam logic [DEPTH_W-1:0] OVER_DEPTH = DEPTH_W'(DEPTH_LIMIT + 1);

	typedef struct {
		logic [KEY_W-1:0] key;
		logic             err;
	} cell_key_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic        [DEPTH_W-1:0] tree_depth;
	logic                      done;
	logic        [KEY_W-1:0]   tile_key;
	logic                      depth_error;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic        [1:0]         cfg_index;
	logic        [31:0]        cfg_data;

	// predictor's copy of the bound registers
	logic signed [31:0] bnd_low_x;
	logic signed [31:0] bnd_low_y;
	logic        [31:0] bnd_span_x;
	logic        [31:0] bnd_span_y;

	cell_key_t   pending_keys[$];
	cell_key_t   want_key;
	int unsigned mismatch_cnt;
	int unsigned keys_checked;
	int unsigned points_sent;
	int unsigned depth_faults;
	int unsigned bound_sets;
	int unsigned burst_left;
	int unsigned stall_cycles;

	point_to_quad_key_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.point_x     (point_x),
		.point_y     (point_y),
		.tree_depth  (tree_depth),
		.done        (done),
		.tile_key    (tile_key),
		.depth_error (depth_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] scale_coord(logic signed [31:0] c, logic signed [31:0] lo,
			logic [31:0] span);
		logic signed [33:0] off;
		logic        [63:0] prod;
		logic        [63:0] q;
		off = {{2{c[31]}}, c} - {{2{lo[31]}}, lo};
		if (off <= 0)
			return '0;
		if (span == 0)
			return '1;
		prod = {31'b0, off[32:0]} * 64'h0000_0000_FFFF_FFFF;
		q    = prod / {32'b0, span};
		return (q > 64'h0000_0000_FFFF_FFFF) ? '1 : q[31:0];
	endfunction

	function automatic logic [63:0] weave(logic [31:0] cx, logic [31:0] cy);
		logic [63:0] w;
		w = '0;
		for (int b = 31; b >= 0; b--)
			w = {w[61:0], cy[b], cx[b]};
		return w;
	endfunction

	function automatic cell_key_t predict_key(logic signed [31:0] x, logic signed [31:0] y,
			logic [DEPTH_W-1:0] d);
		cell_key_t   r;
		logic [63:0] code;
		logic [63:0] full;
		int          lvl;
		lvl = int'(d);
		if (lvl > DEPTH_LIMIT) begin
			r.key = '0;
			r.err = 1'b1;
			return r;
		end
		code = weave(scale_coord(x, bnd_low_x, bnd_span_x), scale_coord(y, bnd_low_y, bnd_span_y));
		full = 64'd1 << (2 * lvl);
		if (lvl != 0)
			full = full | (code >> (64 - 2 * lvl));
		r.key = full[KEY_W-1:0];
		r.err = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checker and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_keys.size() == 0) begin
				$error("unexpected tile_key %h (depth_error %b)", tile_key, depth_error);
				mismatch_cnt++;
			end else begin
				want_key = pending_keys.pop_front();
				keys_checked++;
				if (tile_key !== want_key.key) begin
					$error("tile_key mismatch: expected %h, got %h", want_key.key, tile_key);
					mismatch_cnt++;
				end
				if (depth_error !== want_key.err) begin
					$error("depth_error mismatch: expected %b, got %b", want_key.err,
						depth_error);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r == 0) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [DEPTH_W-1:0] d);
		int unsigned gap;
		cell_key_t   k;
		gap = pick_gap();
		if (gap != 0) begin
			start      <= 1'b0;
			point_x    <= $urandom;
			point_y    <= $urandom;
			tree_depth <= DEPTH_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		point_x    <= x;
		point_y    <= y;
		tree_depth <= d;
		do @(posedge clk); while (busy);
		k = predict_key(x, y, d);
		pending_keys.push_back(k);
		points_sent++;
		if (k.err)
			depth_faults++;
	endtask

	// stop issuing and wait for every pending key to come back
	task automatic drain_keys();
		start <= 1'b0;
		do @(posedge clk); while (pending_keys.size() != 0);
	endtask

	task automatic load_bounds(input logic signed [31:0] lx, input logic signed [31:0] ly,
			input logic [31:0] sx, input logic [31:0] sy);
		cfg_idx_t    order [4];
		logic [31:0] vals  [4];
		order = '{CFG_LOW_X, CFG_LOW_Y, CFG_SPAN_X, CFG_SPAN_Y};
		vals  = '{lx, ly, sx, sy};
		drain_keys();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		bnd_low_x  = lx;
		bnd_low_y  = ly;
		bnd_span_x = sx;
		bnd_span_y = sy;
		bound_sets++;
	endtask

	function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo, logic [31:0] span);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return lo + $urandom_range(0, span);
		if (r < 80) begin
			case ($urandom_range(0, 4))
				0: return lo - 1;
				1: return lo;
				2: return lo + span;
				3: return lo + span + 1;
				default: return lo + (span >> 1);
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [DEPTH_W-1:0] pick_depth();
		if ($urandom_range(0, 99) < 8)
			return DEPTH_W'($urandom_range(DEPTH_LIMIT + 1, 31));
		return DEPTH_W'($urandom_range(0, DEPTH_LIMIT));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// bounds straight out of reset: low 0, span 1
	task automatic test_reset_bounds();
		send_point(0, 0, 0);
		send_point(5, -3, 1);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF, TOP_DEPTH);
		send_point(1, 1, 15);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, TOP_DEPTH);
		send_point(7, 7, OVER_DEPTH);
		send_point(0, 0, 31);
	endtask

	// widest possible bounds, coordinates at both extremes
	task automatic test_full_range();
		load_bounds(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000, TOP_DEPTH);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, TOP_DEPTH);
		send_point(0, 0, 1);
		send_point(0, -1, TOP_DEPTH);
		send_point(-1, 0, 2);
		send_point(12345678, -87654321, TOP_DEPTH);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
	endtask

	// zero span: positive offset saturates, zero or negative gives cell 0
	task automatic test_zero_span();
		load_bounds(32'sh7FFF_FFFF, 0, 32'h0, 32'h0);
		send_point(32'sh7FFF_FFFF, 0, TOP_DEPTH);
		send_point(-5, 1, TOP_DEPTH);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 10);
		send_point(32'sh8000_0000, 32'sh8000_0000, TOP_DEPTH);
	endtask

	// points at, below and past the far edge of tiny bounds
	task automatic test_far_edge();
		load_bounds(1000, -1000, 32'd1, 32'd2);
		send_point(1001, -998, TOP_DEPTH);
		send_point(1002, -997, TOP_DEPTH);
		send_point(1000, -1000, TOP_DEPTH);
		send_point(999, -1001, 20);
	endtask

	task automatic test_random_bounds();
		logic signed [31:0] lx, ly;
		logic        [31:0] sx, sy;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				0: begin
					lx = $urandom;
					ly = $urandom;
					sx = $urandom;
					sy = $urandom;
				end
				1: begin
					lx = $signed($urandom_range(0, 2000)) - 1000;
					ly = $signed($urandom_range(0, 2000)) - 1000;
					sx = $urandom_range(1, 64);
					sy = $urandom_range(1, 64);
				end
				2: begin
					lx = 32'sh8000_0000;
					ly = $urandom;
					sx = 32'hFFFF_FFFF;
					sy = $urandom_range(1, 32'h00FF_FFFF);
				end
				default: begin
					lx = $urandom;
					ly = 32'sh7FFF_FFFF;
					sx = 32'h0;
					sy = $urandom;
				end
			endcase
			load_bounds(lx, ly, sx, sy);
			repeat (PHASE_POINTS)
				send_point(pick_coord(lx, sx), pick_coord(ly, sy), pick_depth());
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		point_x    <= '0;
		point_y    <= '0;
		tree_depth <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_LOW_X;
		cfg_data   <= '0;
		bnd_low_x  = 0;
		bnd_low_y  = 0;
		bnd_span_x = 1;
		bnd_span_y = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_bounds();
		test_full_range();
		test_zero_span();
		test_far_edge();
		test_random_bounds();

		drain_keys();
		// catch any stray done pulses
		repeat (RESULT_LAT + 10) @(posedge clk);

		$display("Encoded %0d points under %0d bound settings, %0d keys checked.",
			points_sent, bound_sets + 1, keys_checked);
		$display("%0d points asked for a depth past the limit.", depth_faults);
		if (mismatch_cnt == 0 && pending_keys.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- point_to_quad_key_encoder.f -----
design/qke_pkg.sv
design/qke_cell.sv
design/qke_key.sv
design/point_to_quad_key_encoder.sv
tb/point_to_quad_key_encoder_tb.sv
